// ===== rtl/assert_macros.svh =====
// assertion macros shared by the console cursor rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/tccw_pkg.sv =====
// shared constants, codes and types of the text console cursor writer
// no dependencies
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int MODE_W  = 2;
  localparam int CHAR_W  = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int INDEX_W = 11;
  localparam int ATTR_W  = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;

  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT  = 2'd0,
    MODE_SET  = 2'd1,
    MODE_BACK = 2'd2
  } mode_t;

  // outcome of one word against the current cursor
  typedef struct packed {
    logic               cell_write;
    logic               scroll;
    logic [INDEX_W-1:0] index;
    logic [CHAR_W-1:0]  glyph;
    logic [ATTR_W-1:0]  attr;
    logic [COL_W-1:0]   column_next;
    logic [ROW_W-1:0]   row_next;
  } step_t;

endpackage

`default_nettype wire

// ===== rtl/tccw_step.sv =====
// cursor step logic: decodes one word and gives the next cursor and results
// depends on tccw_pkg
`default_nettype none

module tccw_step
  import tccw_pkg::*;
(
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic [COL_W-1:0]  column_in,
  input  wire logic [ROW_W-1:0]  row_in,
  input  wire logic [COL_W-1:0]  cursor_column,
  input  wire logic [ROW_W-1:0]  cursor_row,
  input  wire logic [ATTR_W-1:0] attribute,
  output step_t                  step
);

  logic [COL_W:0]           column_inc;
  logic [ROW_W:0]           row_inc;
  logic                     row_over;
  logic [ROW_W-1:0]         row_down;
  logic [INDEX_W+1:0]       index_full;

  assign column_inc = {1'b0, cursor_column} + (COL_W+1)'(1);
  assign row_inc    = {1'b0, cursor_row} + (ROW_W+1)'(1);
  assign row_over   = row_inc >= (ROW_W+1)'(ROWS);
  // next row, held on the last row when it runs off the bottom
  assign row_down   = row_over ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
  assign index_full = (INDEX_W+2)'(cursor_row) * (INDEX_W+2)'(COLUMNS)
                      + (INDEX_W+2)'(cursor_column);

  always_comb begin
    step.cell_write  = 1'b0;
    step.scroll      = 1'b0;
    step.index       = index_full[INDEX_W-1:0];
    step.glyph       = char_code;
    step.attr        = attribute;
    step.column_next = cursor_column;
    step.row_next    = cursor_row;
    unique case (mode_t'(mode))
      MODE_PUT: begin
        if (char_code == CHAR_NEWLINE) begin
          step.column_next = '0;
          step.row_next    = row_down;
          step.scroll      = row_over;
        end else if (char_code != CHAR_BACKSPACE && char_code != CHAR_TAB) begin
          step.cell_write = 1'b1;
          if (column_inc >= (COL_W+1)'(COLUMNS)) begin
            step.column_next = '0;
            step.row_next    = row_down;
            step.scroll      = row_over;
          end else begin
            step.column_next = column_inc[COL_W-1:0];
          end
        end
      end
      MODE_SET: begin
        if ({1'b0, column_in} < (COL_W+1)'(COLUMNS) &&
            {1'b0, row_in} < (ROW_W+1)'(ROWS)) begin
          step.column_next = column_in;
          step.row_next    = row_in;
        end
      end
      MODE_BACK: begin
        if (cursor_column == '0) begin
          step.column_next = COL_W'(COLUMNS - 1);
          if (cursor_row != '0) begin
            step.row_next = cursor_row - ROW_W'(1);
          end
        end else begin
          step.column_next = cursor_column - COL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_cursor_writer.sv =====
// text console cursor writer: word in, cell writes and scroll requests out
// a word waits in the input stage until the output register is free for its result
// throughput: one word per cycle while out_stall is low and no scroll is pending;
// a cell write with a scroll holds the output register for two transfers
// reset: cursor to top-left, attribute to 7, input and output stages empty
// depends on tccw_pkg, tccw_step and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_writer
  import tccw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [ATTR_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [MODE_W-1:0]  mode,
  input  wire logic [CHAR_W-1:0]  char_code,
  input  wire logic [COL_W-1:0]   column_in,
  input  wire logic [ROW_W-1:0]   row_in,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    kind,
  output logic [INDEX_W-1:0]      cell_index,
  output logic [CHAR_W-1:0]       glyph,
  output logic [ATTR_W-1:0]       cell_attribute,
  output logic                    last_of_run
);

  logic [ATTR_W-1:0] attribute;
  logic [COL_W-1:0]  cursor_column;
  logic [ROW_W-1:0]  cursor_row;

  logic              s1_valid;
  logic [MODE_W-1:0] s1_mode;
  logic [CHAR_W-1:0] s1_char;
  logic [COL_W-1:0]  s1_column;
  logic [ROW_W-1:0]  s1_row;

  logic              pending_scroll;
  logic              pending_scroll_next;
  logic              out_valid_next;
  logic              out_free;
  logic              fire;
  logic              in_accept;
  logic              out_take;
  step_t             step;

  // output register can take a new word when empty or draining its last result
  assign out_free  = !out_valid || (!out_stall && !pending_scroll);
  assign fire      = s1_valid && out_free;
  assign in_stall  = s1_valid && !fire;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  tccw_step u_step (
    .mode          (s1_mode),
    .char_code     (s1_char),
    .column_in     (s1_column),
    .row_in        (s1_row),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row),
    .attribute     (attribute),
    .step          (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute     <= ATTR_RESET;
      cursor_column <= '0;
      cursor_row    <= '0;
      s1_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        attribute <= cfg_data;
      end
      if (fire) begin
        cursor_column <= step.column_next;
        cursor_row    <= step.row_next;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode   <= mode;
      s1_char   <= char_code;
      s1_column <= column_in;
      s1_row    <= row_in;
    end
  end

  always_comb begin
    out_valid_next      = out_valid;
    pending_scroll_next = pending_scroll;
    if (out_take) begin
      out_valid_next      = pending_scroll;
      pending_scroll_next = 1'b0;
    end
    if (fire && (step.cell_write || step.scroll)) begin
      out_valid_next      = 1'b1;
      pending_scroll_next = step.cell_write && step.scroll;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      pending_scroll <= 1'b0;
    end else begin
      out_valid      <= out_valid_next;
      pending_scroll <= pending_scroll_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && step.cell_write) begin
      kind           <= KIND_CELL;
      cell_index     <= step.index;
      glyph          <= step.glyph;
      cell_attribute <= step.attr;
      last_of_run    <= !step.scroll;
    end else if ((fire && step.scroll) || (out_take && pending_scroll)) begin
      kind           <= KIND_SCROLL;
      cell_index     <= '0;
      glyph          <= '0;
      cell_attribute <= '0;
      last_of_run    <= 1'b1;
    end
  end

  `ASSERT_PROP(a_pending_has_word, clk, rst, pending_scroll |-> out_valid,
    "scroll pending with empty output register")
  `ASSERT_PROP(a_pending_behind_cell, clk, rst,
    pending_scroll |-> (kind == KIND_CELL && !last_of_run),
    "scroll pending behind a word that is not a non-final cell write")
  `ASSERT_PROP(a_scroll_zero, clk, rst,
    (out_valid && kind == KIND_SCROLL) |-> (cell_index == '0 && last_of_run),
    "scroll word carries index or is not final")
  `ASSERT_PROP(a_cursor_range, clk, rst,
    ({1'b0, cursor_column} < (COL_W+1)'(COLUMNS)) &&
    ({1'b0, cursor_row} < (ROW_W+1)'(ROWS)),
    "cursor outside the screen")
  `ASSERT_PROP(a_drain_after_pending, clk, rst,
    (pending_scroll && !out_stall) |=> (out_valid && kind == KIND_SCROLL),
    "pending scroll not presented after cell write left")

endmodule

`default_nettype wire
